@@ hw/rtl/cdcs_pkg.sv @@
`timescale 1ns / 1ps
package cdcs_pkg;
    localparam int CHANNELS_DEF    = 256;
    localparam int KERNEL_MAX_DEF  = 4;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam logic [1:0] MODE_DATA   = 2'd0;
    localparam logic [1:0] MODE_WEIGHT = 2'd1;
    localparam logic [1:0] MODE_BIAS   = 2'd2;

    localparam logic [1:0] REG_CHANNELS = 2'd0;
    localparam logic [1:0] REG_TAPS     = 2'd1;
    localparam logic [1:0] REG_BIAS_EN  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_TAP,
        ST_ROUND,
        ST_SIG,
        ST_MUL,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic rd_start;
        logic tap_step;
        logic round;
        logic sig;
        logic mul;
        logic commit;
        logic out_take;
    } cmd_t;

    typedef struct packed {
        logic is_sample;
        logic is_load;
        logic last_tap;
    } status_t;

    function automatic logic [16:0] sig_lut(input logic [4:0] k);
        logic [16:0] r;
        case (k)
            5'd0: r = 17'd32768;   5'd1: r = 17'd40793;   5'd2: r = 17'd47911;
            5'd3: r = 17'd53581;   5'd4: r = 17'd57724;   5'd5: r = 17'd60565;
            5'd6: r = 17'd62428;   5'd7: r = 17'd63615;   5'd8: r = 17'd64357;
            5'd9: r = 17'd64816;   5'd10: r = 17'd65097;  5'd11: r = 17'd65269;
            5'd12: r = 17'd65374;  5'd13: r = 17'd65438;  5'd14: r = 17'd65476;
            5'd15: r = 17'd65500;
            default: r = 17'd65514;
        endcase
        return r;
    endfunction
endpackage

@@ hw/rtl/cdcs_ctrl.sv @@
`timescale 1ns / 1ps
module cdcs_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               out_ready,
    output logic               out_valid,
    input  cdcs_pkg::status_t  status,
    output cdcs_pkg::cmd_t     cmd
);
    cdcs_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= cdcs_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            cdcs_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = cdcs_pkg::ST_READ;
                end
            end
            cdcs_pkg::ST_READ:
            begin
                // loads are written here, samples start the tap walk
                if (status.is_sample)
                begin
                    cmd.rd_start = 1'b1;
                    state_next = cdcs_pkg::ST_TAP;
                end
                else
                    state_next = cdcs_pkg::ST_IDLE;
            end
            cdcs_pkg::ST_TAP:
            begin
                cmd.tap_step = 1'b1;
                if (status.last_tap)
                    state_next = cdcs_pkg::ST_ROUND;
            end
            cdcs_pkg::ST_ROUND:
            begin
                cmd.round = 1'b1;
                state_next = cdcs_pkg::ST_SIG;
            end
            cdcs_pkg::ST_SIG:
            begin
                cmd.sig = 1'b1;
                state_next = cdcs_pkg::ST_MUL;
            end
            cdcs_pkg::ST_MUL:
            begin
                cmd.mul = 1'b1;
                cmd.commit = 1'b1;
                state_next = cdcs_pkg::ST_OUT;
            end
            cdcs_pkg::ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.out_take = 1'b1;
                    state_next = cdcs_pkg::ST_IDLE;
                end
            end
            default: state_next = cdcs_pkg::ST_IDLE;
        endcase
    end
endmodule

@@ hw/rtl/cdcs_datapath.sv @@
`timescale 1ns / 1ps
module cdcs_datapath
#(
    parameter int CHANNELS    = cdcs_pkg::CHANNELS_DEF,
    parameter int KERNEL_MAX  = cdcs_pkg::KERNEL_MAX_DEF,
    parameter int SAMPLE_BITS = cdcs_pkg::SAMPLE_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cdcs_pkg::cmd_t           cmd,
    output cdcs_pkg::status_t        status,
    input  logic [1:0]               mode,
    input  logic [7:0]               channel,
    input  logic [1:0]               tap,
    input  logic signed [15:0]       value,
    input  logic                     sequence_start,
    input  logic [8:0]               channels_in_use,
    input  logic [2:0]               kernel_taps,
    input  logic                     bias_enable,
    output logic signed [15:0]       activated,
    output logic [7:0]               out_channel,
    output logic                     saturated
);
    localparam int CW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int TW  = (KERNEL_MAX > 1) ? $clog2(KERNEL_MAX) : 1;
    localparam int KC  = $clog2(KERNEL_MAX + 1);
    localparam int HD  = (KERNEL_MAX > 1) ? KERNEL_MAX - 1 : 1;
    localparam int HW  = (HD > 1) ? $clog2(HD) : 1;
    localparam int FW  = $clog2(KERNEL_MAX);
    localparam int FWX = (FW > 0) ? FW : 1;
    localparam int WA  = (CHANNELS * KERNEL_MAX > 1) ? $clog2(CHANNELS * KERNEL_MAX) : 1;
    localparam int AW  = 48;
    localparam logic signed [AW-1:0] HI = (AW'(1) <<< (SAMPLE_BITS - 1)) - AW'(1);
    localparam logic signed [AW-1:0] LO = -HI - AW'(1);

    // stores
    logic signed [15:0] weight_mem [CHANNELS*KERNEL_MAX];
    logic signed [15:0] bias_mem [CHANNELS];
    logic [HD-1:0][15:0] hist_mem [CHANNELS];
    logic [FWX-1:0]     fill_mem [CHANNELS];
    logic [CHANNELS-1:0] fill_vld_reg;

    // latched request
    logic [1:0]  mode_reg;
    logic [7:0]  ch_reg;
    logic [1:0]  tap_reg;
    logic signed [15:0] val_reg;
    logic        start_reg;

    // channel history and fill count read at acceptance
    logic [HD-1:0][15:0] hist_word_reg;
    logic [HD-1:0][15:0] hist_next;
    logic [FWX-1:0]      fill_ld_reg;

    logic [KC-1:0] kt;
    logic [KC-1:0] t_reg;
    logic [FWX-1:0] fill_reg;
    logic signed [AW-1:0] acc_reg;
    logic signed [15:0] w_q, h_q, b_q;
    logic signed [AW-1:0] x_reg;
    logic [16:0] s_reg;
    logic sat_reg;
    logic signed [15:0] y_reg;
    logic [7:0] och_reg;
    logic [CW-1:0] ci;

    assign ci = CW'(ch_reg);

    always_comb
    begin
        if (kernel_taps == 3'd0)
            kt = KC'(1);
        else if (32'(kernel_taps) > KERNEL_MAX)
            kt = KC'(KERNEL_MAX);
        else
            kt = KC'(kernel_taps);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg      <= mode;
            ch_reg        <= channel;
            tap_reg       <= tap;
            val_reg       <= value;
            start_reg     <= sequence_start;
            hist_word_reg <= hist_mem[CW'(channel)];
            fill_ld_reg   <= fill_vld_reg[CW'(channel)] ? fill_mem[CW'(channel)] : '0;
        end
    end

    assign status.is_sample = (mode_reg == cdcs_pkg::MODE_DATA) &&
                              (32'(ch_reg) < CHANNELS) && ({1'b0, ch_reg} < channels_in_use);
    assign status.is_load = (mode_reg == cdcs_pkg::MODE_WEIGHT) ||
                            (mode_reg == cdcs_pkg::MODE_BIAS);
    assign status.last_tap = (t_reg == kt);

    // tap address for step t: tap index t, lag kt-1-t
    logic [KC-1:0] t_cur, lag;
    logic [WA-1:0] w_rd_addr, w_wr_addr;
    assign t_cur = cmd.rd_start ? KC'(0) : t_reg;
    assign lag = kt - KC'(1) - t_cur;
    assign w_rd_addr = WA'(32'(ci) * KERNEL_MAX + 32'(t_cur));
    assign w_wr_addr = WA'(32'(ch_reg) * KERNEL_MAX + 32'(tap_reg));

    always_ff @(posedge clk)
    begin
        if (mode_reg == cdcs_pkg::MODE_WEIGHT && !cmd.load && !cmd.tap_step &&
            !cmd.rd_start && !cmd.round && !cmd.sig && !cmd.mul && !cmd.out_take &&
            32'(ch_reg) < CHANNELS && 32'(tap_reg) < KERNEL_MAX && status.is_load)
            weight_mem[w_wr_addr] <= val_reg;
        if (mode_reg == cdcs_pkg::MODE_BIAS && !cmd.load && !cmd.tap_step &&
            !cmd.rd_start && !cmd.round && !cmd.sig && !cmd.mul && !cmd.out_take &&
            32'(ch_reg) < CHANNELS && status.is_load)
            bias_mem[ci] <= val_reg;
        if (cmd.rd_start || (cmd.tap_step && !status.last_tap))
        begin
            w_q <= weight_mem[w_rd_addr];
            if (lag != KC'(0))
                h_q <= hist_word_reg[HW'(lag - KC'(1))];
            else
                h_q <= val_reg;
        end
        if (cmd.rd_start)
            b_q <= bias_mem[ci];
    end

    // fill count with valid bits so reset clears it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_vld_reg <= '0;
        else if (cmd.commit)
            fill_vld_reg[ci] <= 1'b1;
    end

    // history holds zero after reset only through fill count gating
    logic [KC-1:0] t_prev;
    logic [KC-1:0] lag_prev;
    logic           step_live_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_live_reg <= 1'b0;
        else
            step_live_reg <= cmd.rd_start || (cmd.tap_step && !status.last_tap);
    end
    assign t_prev = t_reg - KC'(1);
    assign lag_prev = kt - KC'(1) - t_prev;

    logic signed [31:0] prod;
    assign prod = h_q * w_q;

    always_ff @(posedge clk)
    begin
        if (cmd.rd_start)
        begin
            t_reg    <= KC'(1);
            fill_reg <= start_reg ? '0 : fill_ld_reg;
            acc_reg  <= '0;
        end
        else if (cmd.tap_step)
        begin
            if (!status.last_tap)
                t_reg <= t_reg + KC'(1);
            if (step_live_reg && (lag_prev == KC'(0) || 32'(lag_prev) <= 32'(fill_reg)))
                acc_reg <= acc_reg + AW'(prod);
        end
        else if (cmd.round)
        begin
            logic signed [AW-1:0] sum, r;
            sum = acc_reg + (bias_enable ? (AW'(b_q) <<< 14) : AW'(0)) + AW'(8192);
            r = sum >>> 14;
            sat_reg <= (r > HI) || (r < LO);
            x_reg <= (r > HI) ? HI : ((r < LO) ? LO : r);
        end
    end

    // sigmoid lookup with interpolation
    logic [AW-1:0] a;
    logic [AW-12:0] ii;
    logic [10:0] f;
    logic [16:0] t0, t1;
    logic [27:0] interp;
    assign a = x_reg[AW-1] ? AW'(-x_reg) : AW'(x_reg);
    assign ii = a[AW-1:11];
    assign f = a[10:0];
    assign t0 = cdcs_pkg::sig_lut(ii[4:0]);
    assign t1 = cdcs_pkg::sig_lut(ii[4:0] + 5'd1);
    assign interp = 28'(t1 - t0) * 28'(f) + 28'd1024;

    always_ff @(posedge clk)
    begin
        if (cmd.sig)
        begin
            logic [16:0] s;
            if (ii >= (AW-11)'(16))
                s = cdcs_pkg::sig_lut(5'd16);
            else
                s = t0 + 17'(interp >> 11);
            s_reg <= x_reg[AW-1] ? (17'd65536 - s) : s;
        end
    end

    logic signed [AW-1:0] ymul, yr;
    assign ymul = AW'($signed(x_reg[SAMPLE_BITS-1:0])) * AW'($signed({1'b0, s_reg}));
    assign yr = (ymul + AW'(32768)) >>> 16;

    // newest sample first, older ones move down one place
    always_comb
    begin
        hist_next[0] = val_reg;
        for (int j = 1; j < HD; j++)
            hist_next[j] = hist_word_reg[j - 1];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            y_reg   <= (yr > HI) ? HI[15:0] : ((yr < LO) ? LO[15:0] : yr[15:0]);
            saturated <= sat_reg || (yr > HI) || (yr < LO);
            och_reg <= ch_reg;
        end
        if (cmd.commit)
        begin
            hist_mem[ci] <= hist_next;
            if (32'(fill_reg) < KERNEL_MAX - 1)
                fill_mem[ci] <= fill_reg + FWX'(1);
            else
                fill_mem[ci] <= fill_reg;
        end
    end

    assign activated = y_reg;
    assign out_channel = och_reg;
endmodule

@@ hw/rtl/causal_depthwise_conv_silu.sv @@
`timescale 1ns / 1ps
// one request at a time: a load or a dropped sample ends in the read state; a sample
// steps through the read, tap, round, sigmoid, multiply and output states, and the tap
// walk reads one weight and one history word a cycle; the next request waits for its result
// async active-low reset clears control state, configuration registers and fill counts;
// weights and biases are undefined until loaded
module causal_depthwise_conv_silu
#(
    parameter int CHANNELS    = cdcs_pkg::CHANNELS_DEF,
    parameter int KERNEL_MAX  = cdcs_pkg::KERNEL_MAX_DEF,
    parameter int SAMPLE_BITS = cdcs_pkg::SAMPLE_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         mode,
    input  logic [7:0]         channel,
    input  logic [1:0]         tap,
    input  logic signed [15:0] value,
    input  logic               sequence_start,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] activated,
    output logic [7:0]         out_channel,
    output logic               saturated,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [8:0]         cfg_data
);
    cdcs_pkg::cmd_t    cmd;
    cdcs_pkg::status_t status;
    logic [8:0] channels_reg;
    logic [2:0] taps_reg;
    logic       bias_en_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channels_reg <= 9'd256;
            taps_reg     <= 3'd4;
            bias_en_reg  <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cdcs_pkg::REG_CHANNELS: channels_reg <= cfg_data;
                cdcs_pkg::REG_TAPS:     taps_reg <= cfg_data[2:0];
                cdcs_pkg::REG_BIAS_EN:  bias_en_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    cdcs_ctrl u_ctrl
    (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .out_ready(out_ready), .out_valid(out_valid), .status(status), .cmd(cmd)
    );

    cdcs_datapath #(.CHANNELS(CHANNELS), .KERNEL_MAX(KERNEL_MAX),
                    .SAMPLE_BITS(SAMPLE_BITS)) u_dp
    (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .status(status),
        .mode(mode), .channel(channel), .tap(tap), .value(value),
        .sequence_start(sequence_start), .channels_in_use(channels_reg),
        .kernel_taps(taps_reg), .bias_enable(bias_en_reg),
        .activated(activated), .out_channel(out_channel), .saturated(saturated)
    );
endmodule

@@ tb/tb_causal_depthwise_conv_silu.sv @@
`timescale 1ns / 1ps
module tb_causal_depthwise_conv_silu;
    localparam int NCH         = 256;
    localparam int NTAP        = 4;
    localparam int NLOAD       = 48;   // channels given weights and a bias up front
    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE      = 24;   // settle time after the last result, with margin

    typedef struct {
        logic [1:0]         mode;
        logic [7:0]         ch;
        logic [1:0]         tap;
        logic signed [15:0] val;
        logic               start;
    } conv_req_t;

    typedef struct {
        logic signed [15:0] act;
        logic [7:0]         ch;
        logic               sat;
    } silu_res_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         mode = cdcs_pkg::MODE_DATA;
    logic [7:0]         channel = '0;
    logic [1:0]         tap = '0;
    logic signed [15:0] value = '0;
    logic               sequence_start = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [15:0] activated;
    logic [7:0]         out_channel;
    logic               saturated;
    logic               cfg_we = 1'b0;
    logic [1:0]         cfg_index = cdcs_pkg::REG_CHANNELS;
    logic [8:0]         cfg_data = '0;

    // stimulus waiting for the driver, and results still owed by the block
    conv_req_t pending_reqs[$];
    silu_res_t owed_results[$];

    // predictor state and its copy of the register settings
    logic signed [15:0] hist_q [NCH][NTAP-1];
    int                 fill_q [NCH];
    logic signed [15:0] wt_q   [NCH][NTAP];
    logic signed [15:0] bias_q [NCH];
    int                 ch_limit = 256;
    int                 taps_cfg = 4;
    bit                 bias_on = 1'b1;

    int  errors = 0;
    int  accepted_reqs = 0;
    int  seen_results = 0;
    int  cycles = 0;
    int  hold_cnt = 0;
    bit  hold_done = 1'b0;

    const int sig_lut_q[17] = '{32768, 40793, 47911, 53581, 57724, 60565, 62428,
        63615, 64357, 64816, 65097, 65269, 65374, 65438, 65476, 65500, 65514};

    causal_depthwise_conv_silu i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .mode(mode), .channel(channel), .tap(tap), .value(value),
        .sequence_start(sequence_start),
        .out_valid(out_valid), .out_ready(out_ready),
        .activated(activated), .out_channel(out_channel), .saturated(saturated),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // clip to the signed 16-bit range, flagging any clipping
    function automatic longint clip16(input longint v, inout bit sat);
        if (v > 32767)
        begin
            sat = 1'b1;
            return 32767;
        end
        if (v < -32768)
        begin
            sat = 1'b1;
            return -32768;
        end
        return v;
    endfunction

    // sigmoid in Q0.16 by linear interpolation between half-unit table points
    function automatic longint sigmoid_q16(input longint x);
        longint a;
        longint i;
        longint s;
        a = (x < 0) ? -x : x;
        i = a >> 11;
        if (i >= 16)
            s = sig_lut_q[16];
        else
            s = sig_lut_q[i] + (((sig_lut_q[i+1] - sig_lut_q[i]) * (a & 2047) + 1024) >> 11);
        if (x < 0)
            s = 65536 - s;
        return s;
    endfunction

    // update the predictor for one accepted request; samples owe one result
    task automatic predict_conv(input conv_req_t r);
        int        kt;
        int        lag;
        int        fill;
        longint    acc;
        longint    x;
        longint    y;
        bit        sat;
        silu_res_t res;
        sat = 1'b0;
        if (r.mode == cdcs_pkg::MODE_WEIGHT)
            wt_q[r.ch][r.tap] = r.val;
        else if (r.mode == cdcs_pkg::MODE_BIAS)
            bias_q[r.ch] = r.val;
        else if (r.mode == cdcs_pkg::MODE_DATA && int'(r.ch) < ch_limit)
        begin
            kt = (taps_cfg < 1) ? 1 : (taps_cfg > NTAP) ? NTAP : taps_cfg;
            if (r.start)
                fill_q[r.ch] = 0;
            fill = fill_q[r.ch];
            acc = bias_on ? longint'(bias_q[r.ch]) * 16384 : 0;
            for (int t = 0; t < kt; t++)
            begin
                lag = kt - 1 - t;
                if (lag == 0)
                    acc += longint'(r.val) * longint'(wt_q[r.ch][t]);
                else if (lag <= fill)
                    acc += longint'(hist_q[r.ch][lag-1]) * longint'(wt_q[r.ch][t]);
            end
            x = clip16((acc + 8192) >>> 14, sat);
            y = clip16((x * sigmoid_q16(x) + 32768) >>> 16, sat);
            hist_q[r.ch][2] = hist_q[r.ch][1];
            hist_q[r.ch][1] = hist_q[r.ch][0];
            hist_q[r.ch][0] = r.val;
            if (fill < NTAP - 1)
                fill_q[r.ch] = fill + 1;
            res.act = y[15:0];
            res.ch  = r.ch;
            res.sat = sat;
            owed_results.push_back(res);
        end
    endtask

    // driver: offers queued requests, idling now and then except in a quiet stretch
    always @(posedge clk or negedge rst_n)
    begin
        conv_req_t r;
        bit        quiet;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                r = '{mode, channel, tap, value, sequence_start};
                predict_conv(r);
                accepted_reqs++;
            end
            quiet = (accepted_reqs >= 300 && accepted_reqs < 450);
            if (in_valid && !in_ready)
                ; // hold the request until it is taken
            else if (pending_reqs.size() > 0 && (quiet || $urandom_range(99) >= 13))
            begin
                r = pending_reqs.pop_front();
                in_valid       <= 1'b1;
                mode           <= r.mode;
                channel        <= r.ch;
                tap            <= r.tap;
                value          <= r.val;
                sequence_start <= r.start;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor: checks each result against the oldest prediction and drives out_ready
    always @(posedge clk or negedge rst_n)
    begin
        silu_res_t e;
        bit        quiet;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                seen_results++;
                if (owed_results.size() == 0)
                begin
                    $error("result with nothing owed: channel %0d", out_channel);
                    errors++;
                end
                else
                begin
                    e = owed_results.pop_front();
                    if (activated !== e.act)
                    begin
                        $error("activated: expected %0d, got %0d", e.act, activated);
                        errors++;
                    end
                    if (out_channel !== e.ch)
                    begin
                        $error("out_channel: expected %0d, got %0d", e.ch, out_channel);
                        errors++;
                    end
                    if (saturated !== e.sat)
                    begin
                        $error("saturated: expected %0d, got %0d", e.sat, saturated);
                        errors++;
                    end
                end
            end
            // one long hold-off so the block backs up and stalls its input
            if (!hold_done && seen_results == 60)
            begin
                hold_done = 1'b1;
                hold_cnt = 300;
            end
            quiet = (seen_results >= 150 && seen_results < 250);
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= quiet || ($urandom_range(99) >= 13);
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic signed [15:0] rand_value();
        case ($urandom_range(9))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2, 3, 4: return 16'($urandom);
            default: return 16'($signed($urandom_range(8191)) - 4096);
        endcase
    endfunction

    task automatic add_req(input logic [1:0] m, input int ch, input int tp,
                           input logic signed [15:0] v, input int st);
        conv_req_t r;
        r = '{m, ch[7:0], tp[1:0], v, st[0]};
        pending_reqs.push_back(r);
    endtask

    // wait for the block to go idle: nothing queued, nothing offered, nothing owed
    task automatic drain();
        while (pending_reqs.size() > 0 || in_valid || owed_results.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int d);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d[8:0];
        if (idx == cdcs_pkg::REG_CHANNELS)
            ch_limit = d & 9'h1ff;
        else if (idx == cdcs_pkg::REG_TAPS)
            taps_cfg = d & 7;
        else
            bias_on = d[0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // mostly well-formed sample streams, with some reloads, dropped channels and noise;
    // samples that can give a result only use channels loaded up front
    task automatic add_random(input int n);
        int pick;
        int ch;
        int lim;
        for (int k = 0; k < n; k++)
        begin
            pick = $urandom_range(99);
            lim = (ch_limit < NLOAD) ? ch_limit : NLOAD;
            ch = (lim > 0) ? $urandom_range(lim - 1) : 0;
            if (pick < 84)
                add_req(cdcs_pkg::MODE_DATA, ch, $urandom_range(3), rand_value(),
                        ($urandom_range(9) == 0) ? 1 : 0);
            else if (pick < 89)
            begin
                if (ch_limit < 256)
                    ch = $urandom_range(255, ch_limit);
                else
                    ch = $urandom_range(NLOAD - 1);
                add_req(cdcs_pkg::MODE_DATA, ch, $urandom_range(3), rand_value(),
                        $urandom_range(1));
            end
            else if (pick < 94)
                add_req(cdcs_pkg::MODE_WEIGHT, $urandom_range(255), $urandom_range(3),
                        rand_value(), 0);
            else if (pick < 97)
                add_req(cdcs_pkg::MODE_BIAS, $urandom_range(255), $urandom_range(3),
                        rand_value(), 0);
            else
                add_req(2'd3, $urandom_range(255), $urandom_range(3), 16'($urandom),
                        $urandom_range(1));
        end
    endtask

    initial
    begin
        for (int c = 0; c < NCH; c++)
        begin
            fill_q[c] = 0;
            for (int j = 0; j < NTAP - 1; j++)
                hist_q[c][j] = '0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // weights and biases of every channel that samples use are loaded before any sample reads them
        for (int c = 0; c < NLOAD; c++)
        begin
            for (int t = 0; t < NTAP; t++)
                add_req(cdcs_pkg::MODE_WEIGHT, c, t, rand_value(), 0);
            add_req(cdcs_pkg::MODE_BIAS, c, 0, rand_value(), 0);
        end
        for (int t = 0; t < NTAP; t++)
            add_req(cdcs_pkg::MODE_WEIGHT, 255, t, rand_value(), 0);
        add_req(cdcs_pkg::MODE_BIAS, 255, 0, rand_value(), 0);

        // directed: full-scale weights and bias on channel 0 to force clipping
        for (int t = 0; t < NTAP; t++)
            add_req(cdcs_pkg::MODE_WEIGHT, 0, t, 16'sh7fff, 0);
        add_req(cdcs_pkg::MODE_BIAS, 0, 0, 16'sh7fff, 0);
        add_req(cdcs_pkg::MODE_DATA, 0, 0, 16'sh7fff, 1);
        add_req(cdcs_pkg::MODE_DATA, 0, 0, 16'sh7fff, 0);
        add_req(cdcs_pkg::MODE_DATA, 0, 0, 16'sh7fff, 0);
        add_req(cdcs_pkg::MODE_DATA, 0, 0, 16'sh7fff, 0);
        add_req(cdcs_pkg::MODE_DATA, 0, 3, 16'sh8000, 1);    // restart flushes older taps
        add_req(cdcs_pkg::MODE_WEIGHT, 255, 3, 16'sh8000, 0);
        add_req(cdcs_pkg::MODE_BIAS, 255, 0, 16'sh8000, 0);
        add_req(cdcs_pkg::MODE_DATA, 255, 0, 16'sh8000, 1);
        add_req(cdcs_pkg::MODE_DATA, 255, 0, 16'sh0000, 0);
        add_req(cdcs_pkg::MODE_DATA, 255, 0, 16'sh7fff, 0);
        add_req(2'd3, 255, 3, 16'shffff, 1);                 // unused mode, no result
        add_req(cdcs_pkg::MODE_DATA, 7, 0, 16'sh0001, 1);
        add_req(cdcs_pkg::MODE_DATA, 7, 0, 16'shffff, 0);
        add_random(80);
        drain();

        // one channel, one tap, no bias: other channels are dropped
        write_reg(cdcs_pkg::REG_CHANNELS, 1);
        write_reg(cdcs_pkg::REG_TAPS, 1);
        write_reg(cdcs_pkg::REG_BIAS_EN, 0);
        add_req(cdcs_pkg::MODE_DATA, 1, 0, 16'sh1000, 0);
        add_req(cdcs_pkg::MODE_DATA, 0, 0, 16'sh1000, 0);
        add_random(60);
        drain();

        write_reg(cdcs_pkg::REG_CHANNELS, 17);
        write_reg(cdcs_pkg::REG_TAPS, 3);
        write_reg(cdcs_pkg::REG_BIAS_EN, 1);
        add_random(80);
        drain();

        // tap count of zero acts as one
        write_reg(cdcs_pkg::REG_CHANNELS, 100);
        write_reg(cdcs_pkg::REG_TAPS, 0);
        write_reg(cdcs_pkg::REG_BIAS_EN, 0);
        add_random(60);
        drain();

        // tap count above the maximum acts as the maximum; all channels open
        write_reg(cdcs_pkg::REG_CHANNELS, 511);
        write_reg(cdcs_pkg::REG_TAPS, 7);
        write_reg(cdcs_pkg::REG_BIAS_EN, 1);
        add_random(80);
        drain();

        write_reg(cdcs_pkg::REG_CHANNELS, 4);
        write_reg(cdcs_pkg::REG_TAPS, 2);
        add_random(60);
        drain();

        // zero channels: every sample dropped
        write_reg(cdcs_pkg::REG_CHANNELS, 0);
        add_random(20);
        drain();

        write_reg(cdcs_pkg::REG_CHANNELS, 256);
        write_reg(cdcs_pkg::REG_TAPS, 4);
        add_random(100);
        drain();

        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
